FILE: design/lafi_pkg.sv
package lafi_pkg;

  localparam int TAPS_DEF   = 4;
  localparam int QSHIFT     = 15;
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_A_W    = SAMPLE_W + STEP_W + 1;
  localparam int PROD_W     = MUL_A_W + SAMPLE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd4;

  localparam logic signed [SAMPLE_W-1:0] COEF_RST = 16'sd8192;
  localparam logic [STEP_W-1:0]          STEP_RST = 10'd5;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] error_out;
  } error_t;

  typedef enum logic [1:0] {
    OP_REF  = 2'd0,
    OP_ADP  = 2'd1,
    OP_STEP = 2'd2,
    OP_UPD  = 2'd3
  } mul_op_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FILT  = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_ERR   = 7'b0001000,
    S_SE    = 7'b0010000,
    S_UPD   = 7'b0100000,
    S_WB    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic    load_sample;
    logic    load_err;
    logic    mul_en;
    mul_op_t op;
    logic    tap_new;
    logic    samp_vld;
    logic    wgt_vld;
  } ctrl_t;

endpackage

FILE: design/lafi_stream_if.sv
interface lafi_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/lafi_ram.sv
module lafi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lafi_seq.sv
module lafi_seq
  import lafi_pkg::*;
#(
  parameter int TAPS = TAPS_DEF,
  localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1,
  localparam int CW = $clog2(2 * TAPS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ctrl_t         ctrl,
  output logic [AW-1:0] coef_idx,
  output logic [AW-1:0] wgt_raddr,
  output logic [AW-1:0] wgt_waddr,
  output logic          wgt_we,
  output logic [AW-1:0] samp_raddr,
  output logic [AW-1:0] samp_waddr,
  output logic          samp_we
);

  state_t          state;
  logic [CW-1:0]   cnt;
  logic [AW-1:0]   ptr;
  logic [TAPS-1:0] hist_vld;
  logic [TAPS-1:0] wgt_vld;
  logic [CW-1:0]   dat_idx;
  logic [CW-1:0]   wb_idx;
  logic [CW-1:0]   rd_idx;
  logic [CW-1:0]   ptr_ext;
  logic [CW-1:0]   samp_off;
  logic            samp_vld_q;
  logic            wgt_vld_q;
  logic            accept;
  logic            err_go;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign err_go   = (state == S_ERR) && (!out_valid || out_ready);

  always_comb begin
    unique case (state)
      S_FILT:  rd_idx = CW'((cnt + CW'(1)) >> 1);
      S_UPD:   rd_idx = cnt + CW'(1);
      default: rd_idx = '0;
    endcase
  end

  assign ptr_ext = CW'(ptr);

  always_comb begin
    if (ptr_ext >= rd_idx) begin
      samp_off = ptr_ext - rd_idx;
    end else begin
      samp_off = ptr_ext + CW'(TAPS) - rd_idx;
    end
  end

  assign samp_raddr = samp_off[AW-1:0];
  assign wgt_raddr  = (rd_idx < CW'(TAPS)) ? rd_idx[AW-1:0] : '0;
  assign samp_waddr = ptr;
  assign samp_we    = accept;
  assign wgt_waddr  = wb_idx[AW-1:0];
  assign wgt_we     = ((state == S_UPD) && (cnt != '0)) || (state == S_WB);
  assign coef_idx   = dat_idx[AW-1:0];

  always_comb begin
    ctrl.load_sample = accept;
    ctrl.load_err    = err_go;
    ctrl.tap_new     = (dat_idx == '0);
    ctrl.samp_vld    = samp_vld_q;
    ctrl.wgt_vld     = wgt_vld_q;
    unique case (state)
      S_FILT: begin
        ctrl.mul_en = 1'b1;
        ctrl.op     = cnt[0] ? OP_ADP : OP_REF;
      end
      S_ERR: begin
        ctrl.mul_en = err_go;
        ctrl.op     = OP_STEP;
      end
      S_UPD: begin
        ctrl.mul_en = 1'b1;
        ctrl.op     = OP_UPD;
      end
      default: begin
        ctrl.mul_en = 1'b0;
        ctrl.op     = OP_REF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      ptr        <= '0;
      hist_vld   <= '0;
      wgt_vld    <= '0;
      dat_idx    <= '0;
      wb_idx     <= '0;
      samp_vld_q <= 1'b0;
      wgt_vld_q  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      dat_idx    <= rd_idx;
      wb_idx     <= dat_idx;
      samp_vld_q <= hist_vld[samp_raddr];
      wgt_vld_q  <= wgt_vld[wgt_raddr];
      if (accept) begin
        hist_vld[ptr] <= 1'b1;
      end
      if (wgt_we) begin
        wgt_vld[wgt_waddr] <= 1'b1;
      end
      if (err_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= S_FILT;
          end
        end
        S_FILT: begin
          if (cnt == CW'(2 * TAPS - 1)) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_ERR;
        end
        S_ERR: begin
          if (err_go) begin
            state <= S_SE;
          end
        end
        S_SE: begin
          cnt   <= '0;
          state <= S_UPD;
        end
        S_UPD: begin
          if (cnt == CW'(TAPS - 1)) begin
            state <= S_WB;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_WB: begin
          ptr   <= (ptr == AW'(TAPS - 1)) ? '0 : ptr + AW'(1);
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/lafi_dp.sv
module lafi_dp
  import lafi_pkg::*;
#(
  parameter int TAPS = TAPS_DEF,
  localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  ctrl_t                      ctrl,
  input  logic [AW-1:0]              coef_idx,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic signed [SAMPLE_W-1:0] samp_rdata,
  input  logic signed [SAMPLE_W-1:0] wgt_rdata,
  output logic signed [SAMPLE_W-1:0] wgt_wdata,
  output logic signed [SAMPLE_W-1:0] error_out
);

  logic signed [SAMPLE_W-1:0] coef [TAPS];
  logic [STEP_W-1:0]          step;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] tap_val;
  logic signed [SAMPLE_W-1:0] wgt_val;
  logic signed [SAMPLE_W-1:0] d_acc;
  logic signed [SAMPLE_W-1:0] y_acc;
  logic signed [SAMPLE_W-1:0] err;
  logic signed [SAMPLE_W-1:0] w_hold;
  logic signed [SAMPLE_W-1:0] prod_lo;
  logic signed [MUL_A_W-1:0]  se_q;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic signed [PROD_W-1:0]   mul_full;
  logic signed [PROD_W-1:0]   prod;
  logic                       prod_vld;
  mul_op_t                    prod_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        coef[k] <= COEF_RST;
      end
      step <= STEP_RST;
    end else if (cfg_we) begin
      for (int k = 0; k < TAPS; k++) begin
        if (cfg_index == CFG_COEF_BASE + CFG_IDX_W'(k)) begin
          coef[k] <= cfg_data[SAMPLE_W-1:0];
        end
      end
      if (cfg_index == CFG_STEP) begin
        step <= cfg_data[STEP_W-1:0];
      end
    end
  end

  assign tap_val = ctrl.tap_new ? sample_q : (ctrl.samp_vld ? samp_rdata : '0);
  assign wgt_val = ctrl.wgt_vld ? wgt_rdata : '0;
  assign err     = d_acc - y_acc;
  assign prod_lo = prod[QSHIFT+SAMPLE_W-1:QSHIFT];

  always_comb begin
    unique case (ctrl.op)
      OP_REF: begin
        mul_a = MUL_A_W'(coef[coef_idx]);
        mul_b = tap_val;
      end
      OP_ADP: begin
        mul_a = MUL_A_W'(wgt_val);
        mul_b = tap_val;
      end
      OP_STEP: begin
        mul_a = MUL_A_W'(err);
        mul_b = $signed({{(SAMPLE_W - STEP_W){1'b0}}, step});
      end
      OP_UPD: begin
        mul_a = se_q;
        mul_b = tap_val;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      prod_op  <= OP_REF;
    end else begin
      prod_vld <= ctrl.mul_en;
      prod_op  <= ctrl.op;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= mul_full;
    end
    if (ctrl.mul_en && (ctrl.op == OP_UPD)) begin
      w_hold <= wgt_val;
    end
    if (ctrl.load_sample) begin
      sample_q <= sample_in;
    end
    if (ctrl.load_err) begin
      error_out <= err;
    end
    if (ctrl.load_sample) begin
      d_acc <= '0;
      y_acc <= '0;
    end else if (prod_vld && (prod_op == OP_REF)) begin
      d_acc <= d_acc + prod_lo;
    end else if (prod_vld && (prod_op == OP_ADP)) begin
      y_acc <= y_acc + prod_lo;
    end
    if (prod_vld && (prod_op == OP_STEP)) begin
      se_q <= prod[MUL_A_W-1:0];
    end
  end

  assign wgt_wdata = w_hold + prod_lo;

endmodule

FILE: design/lms_adaptive_fir_identifier.sv
// Channel   Dir  Payload                 Accepted when
// samples   in   sample_in  s16 Q15      samples.valid & samples.ready
// errors    out  error_out  s16          errors.valid & errors.ready
//
// A new sample is taken only after the last one is written back; the single
// shared 27x16 multiplier does two products per tap for the filters, one for
// step*error, one per tap for the weight update, all through registered RAMs.
// rst loads coefficient defaults; weights and history read as zero through
// per-entry valid bits, so no clearing pass is run.
// A result still waiting at the output holds the block before the update.
module lms_adaptive_fir_identifier
  import lafi_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lafi_stream_if.sink           samples,
  lafi_stream_if.source         errors
);

  localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;

  ctrl_t                      ctrl;
  logic [AW-1:0]              coef_idx;
  logic [AW-1:0]              wgt_raddr;
  logic [AW-1:0]              wgt_waddr;
  logic                       wgt_we;
  logic [AW-1:0]              samp_raddr;
  logic [AW-1:0]              samp_waddr;
  logic                       samp_we;
  logic signed [SAMPLE_W-1:0] samp_rdata;
  logic signed [SAMPLE_W-1:0] wgt_rdata;
  logic signed [SAMPLE_W-1:0] wgt_wdata;
  logic signed [SAMPLE_W-1:0] err_q;

  lafi_seq #(.TAPS(TAPS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (errors.valid),
    .out_ready (errors.ready),
    .ctrl      (ctrl),
    .coef_idx  (coef_idx),
    .wgt_raddr (wgt_raddr),
    .wgt_waddr (wgt_waddr),
    .wgt_we    (wgt_we),
    .samp_raddr(samp_raddr),
    .samp_waddr(samp_waddr),
    .samp_we   (samp_we)
  );

  lafi_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_hist_ram (
    .clk  (clk),
    .we   (samp_we),
    .waddr(samp_waddr),
    .wdata(samples.payload.sample_in),
    .raddr(samp_raddr),
    .rdata(samp_rdata)
  );

  lafi_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_wgt_ram (
    .clk  (clk),
    .we   (wgt_we),
    .waddr(wgt_waddr),
    .wdata(wgt_wdata),
    .raddr(wgt_raddr),
    .rdata(wgt_rdata)
  );

  lafi_dp #(.TAPS(TAPS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .coef_idx  (coef_idx),
    .sample_in (samples.payload.sample_in),
    .samp_rdata(samp_rdata),
    .wgt_rdata (wgt_rdata),
    .wgt_wdata (wgt_wdata),
    .error_out (err_q)
  );

  assign errors.payload.error_out = err_q;

endmodule
